FILE: hw/rtl/vtu_pkg.sv
// Shared types, codes and reset constants of the vertex transform unit.
package vtu_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [2:0] MODE_IDENTITY = 3'd0;
  localparam logic [2:0] MODE_ROT_X    = 3'd1;
  localparam logic [2:0] MODE_ROT_Y    = 3'd2;
  localparam logic [2:0] MODE_ROT_Z    = 3'd3;
  localparam logic [2:0] MODE_SCALE    = 3'd4;
  localparam logic [2:0] MODE_SHIFT_X  = 3'd5;
  localparam logic [2:0] MODE_SHIFT_Y  = 3'd6;
  localparam logic [2:0] MODE_SHIFT_Z  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [2:0]         MODE_RST  = MODE_IDENTITY;
  localparam logic [COEF_W-1:0]  COS_RST   = 16'h4000;
  localparam logic [COEF_W-1:0]  SIN_RST   = 16'h0000;
  localparam logic [COORD_W-1:0] SCALE_RST = 32'h0001_0000;
  localparam logic [COORD_W-1:0] SHIFT_RST = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ROT,
    OP_SCALE,
    OP_SHIFT
  } op_e;

  typedef enum logic [1:0] {
    RND_NONE,
    RND_Q14,
    RND_Q16
  } rnd_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis_a;
    logic [1:0] axis_b;
  } cmd_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] v;
    logic                    restart;
    cmd_t                    cmd;
  } item_t;

  typedef struct packed {
    logic [COEF_W-1:0]  cos_coef;
    logic [COEF_W-1:0]  sin_coef;
    logic [COORD_W-1:0] scale_factor;
    logic [COORD_W-1:0] shift_amount;
  } cfg_t;

endpackage

FILE: hw/rtl/vtu_front.sv
// Front end: accepts vertex requests and decodes the transform mode into a command.
module vtu_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [3*vtu_pkg::COORD_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic [2:0]                       mode_i,
  output vtu_pkg::item_t                   item_o,
  output logic                             valid_o,
  input  logic                             ready_i
);

  vtu_pkg::cmd_t  cmd_d;
  vtu_pkg::item_t item_d;
  vtu_pkg::item_t item_q;
  logic           valid_q;
  logic           accept;

  always_comb begin
    cmd_d = '{op: vtu_pkg::OP_PASS, axis_a: vtu_pkg::AXIS_X, axis_b: vtu_pkg::AXIS_X};
    unique case (mode_i)
      vtu_pkg::MODE_IDENTITY: cmd_d.op = vtu_pkg::OP_PASS;
      vtu_pkg::MODE_ROT_X: begin
        cmd_d = '{op: vtu_pkg::OP_ROT, axis_a: vtu_pkg::AXIS_Y, axis_b: vtu_pkg::AXIS_Z};
      end
      vtu_pkg::MODE_ROT_Y: begin
        cmd_d = '{op: vtu_pkg::OP_ROT, axis_a: vtu_pkg::AXIS_X, axis_b: vtu_pkg::AXIS_Z};
      end
      vtu_pkg::MODE_ROT_Z: begin
        cmd_d = '{op: vtu_pkg::OP_ROT, axis_a: vtu_pkg::AXIS_X, axis_b: vtu_pkg::AXIS_Y};
      end
      vtu_pkg::MODE_SCALE: cmd_d.op = vtu_pkg::OP_SCALE;
      vtu_pkg::MODE_SHIFT_X: begin
        cmd_d = '{op: vtu_pkg::OP_SHIFT, axis_a: vtu_pkg::AXIS_X, axis_b: vtu_pkg::AXIS_X};
      end
      vtu_pkg::MODE_SHIFT_Y: begin
        cmd_d = '{op: vtu_pkg::OP_SHIFT, axis_a: vtu_pkg::AXIS_Y, axis_b: vtu_pkg::AXIS_Y};
      end
      vtu_pkg::MODE_SHIFT_Z: begin
        cmd_d = '{op: vtu_pkg::OP_SHIFT, axis_a: vtu_pkg::AXIS_Z, axis_b: vtu_pkg::AXIS_Z};
      end
      default: cmd_d.op = vtu_pkg::OP_PASS;
    endcase
  end

  always_comb begin
    item_d.v       = s_axis_tdata;
    item_d.restart = s_axis_tuser;
    item_d.cmd     = cmd_d;
  end

  assign s_axis_tready = !valid_q || ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

FILE: hw/rtl/vtu_queue.sv
// Small first-in first-out queue of decoded requests between front and back end.
module vtu_queue #(
  parameter int unsigned DEPTH = vtu_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vtu_pkg::item_t item_i,
  input  logic           valid_i,
  output logic           ready_o,
  output vtu_pkg::item_t item_o,
  output logic           valid_o,
  input  logic           ready_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  vtu_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d;
  logic [PW-1:0]  rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push, pop;

  assign ready_o = cnt_q != CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("Queue fill count exceeds its depth.");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
    else $error("Queue fill count did not follow a lone push.");

endmodule

FILE: hw/rtl/vtu_back.sv
// Back end: multiply, add and round, shift and saturate, then bounding box update.
module vtu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vtu_pkg::item_t                item_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  vtu_pkg::cfg_t                 cfg_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [9*vtu_pkg::COORD_W-1:0] m_axis_tdata
);

  localparam int unsigned WW = 66;
  localparam logic signed [WW-1:0] SAT_HI   = 66'sd2147483647;
  localparam logic signed [WW-1:0] SAT_LO   = -66'sd2147483648;
  localparam logic signed [WW-1:0] HALF_Q14 = 66'sd8192;
  localparam logic signed [WW-1:0] HALF_Q16 = 66'sd32768;
  localparam logic [31:0] CORNER_LO_RST = 32'h7FFF_FFFF;
  localparam logic [31:0] CORNER_HI_RST = 32'h8000_0000;

  function automatic logic signed [WW-1:0] wide32(logic [31:0] a);
    return {{(WW-32){a[31]}}, a};
  endfunction

  function automatic logic signed [WW-1:0] wide64(logic [63:0] a);
    return {{(WW-64){a[63]}}, a};
  endfunction

  logic rdy1, rdy2, rdy3, rdy4;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;

  vtu_pkg::item_t     s1_item_q;
  logic signed [31:0] opa [4];
  logic signed [31:0] opb [4];
  logic signed [63:0] prod_d [4];
  logic signed [63:0] prod_q [4];

  logic signed [WW-1:0] w_d [3];
  logic signed [WW-1:0] w_q [3];
  vtu_pkg::rnd_e        rnd_d [3];
  vtu_pkg::rnd_e        rnd_q [3];
  logic                 s2_restart_q;

  logic signed [WW-1:0] sh [3];
  logic signed [31:0]   v_d [3];
  logic signed [31:0]   v_q [3];
  logic                 s3_restart_q;

  logic signed [31:0] out_v_q [3];
  logic signed [31:0] lo_d [3];
  logic signed [31:0] lo_q [3];
  logic signed [31:0] hi_d [3];
  logic signed [31:0] hi_q [3];

  logic signed [31:0] cos_s, sin_s;

  assign rdy4    = !s4_vld_q || m_axis_tready;
  assign rdy3    = !s3_vld_q || rdy4;
  assign rdy2    = !s2_vld_q || rdy3;
  assign rdy1    = !s1_vld_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_vld_q <= valid_i;
      end
      if (rdy2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (rdy3) begin
        s3_vld_q <= s2_vld_q;
      end
      if (rdy4) begin
        s4_vld_q <= s3_vld_q;
      end
    end
  end

  assign cos_s = {{16{cfg_i.cos_coef[15]}}, cfg_i.cos_coef};
  assign sin_s = {{16{cfg_i.sin_coef[15]}}, cfg_i.sin_coef};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    case (item_i.cmd.op)
      vtu_pkg::OP_ROT: begin
        opa[0] = item_i.v[item_i.cmd.axis_a];
        opb[0] = cos_s;
        opa[1] = item_i.v[item_i.cmd.axis_b];
        opb[1] = sin_s;
        opa[2] = item_i.v[item_i.cmd.axis_a];
        opb[2] = sin_s;
        opa[3] = item_i.v[item_i.cmd.axis_b];
        opb[3] = cos_s;
      end
      vtu_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = item_i.v[i];
          opb[i] = cfg_i.scale_factor;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = opa[i] * opb[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      s1_item_q <= item_i;
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_d[i]   = wide32(s1_item_q.v[i]);
      rnd_d[i] = vtu_pkg::RND_NONE;
    end
    case (s1_item_q.cmd.op)
      vtu_pkg::OP_ROT: begin
        w_d[s1_item_q.cmd.axis_a]   = wide64(prod_q[0]) - wide64(prod_q[1]) + HALF_Q14;
        rnd_d[s1_item_q.cmd.axis_a] = vtu_pkg::RND_Q14;
        w_d[s1_item_q.cmd.axis_b]   = wide64(prod_q[2]) + wide64(prod_q[3]) + HALF_Q14;
        rnd_d[s1_item_q.cmd.axis_b] = vtu_pkg::RND_Q14;
      end
      vtu_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          w_d[i]   = wide64(prod_q[i]) + HALF_Q16;
          rnd_d[i] = vtu_pkg::RND_Q16;
        end
      end
      vtu_pkg::OP_SHIFT: begin
        w_d[s1_item_q.cmd.axis_a] = wide32(s1_item_q.v[s1_item_q.cmd.axis_a])
                                    + wide32(cfg_i.shift_amount);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_vld_q) begin
      s2_restart_q <= s1_item_q.restart;
      for (int i = 0; i < 3; i++) begin
        w_q[i]   <= w_d[i];
        rnd_q[i] <= rnd_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (rnd_q[i])
        vtu_pkg::RND_Q14: sh[i] = w_q[i] >>> 14;
        vtu_pkg::RND_Q16: sh[i] = w_q[i] >>> 16;
        default:          sh[i] = w_q[i];
      endcase
      if (sh[i] > SAT_HI) begin
        v_d[i] = SAT_HI[31:0];
      end else if (sh[i] < SAT_LO) begin
        v_d[i] = SAT_LO[31:0];
      end else begin
        v_d[i] = sh[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_vld_q) begin
      s3_restart_q <= s2_restart_q;
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= v_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s3_restart_q) begin
        lo_d[i] = v_q[i];
        hi_d[i] = v_q[i];
      end else begin
        lo_d[i] = (v_q[i] < lo_q[i]) ? v_q[i] : lo_q[i];
        hi_d[i] = (v_q[i] > hi_q[i]) ? v_q[i] : hi_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= CORNER_LO_RST;
        hi_q[i] <= CORNER_HI_RST;
      end
    end else if (rdy4 && s3_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= lo_d[i];
        hi_q[i] <= hi_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        out_v_q[i] <= v_q[i];
      end
    end
  end

  assign m_axis_tvalid = s4_vld_q;
  assign m_axis_tdata  = {hi_q[2], lo_q[2], hi_q[1], lo_q[1], hi_q[0], lo_q[0],
                          out_v_q[2], out_v_q[1], out_v_q[0]};

  a_box_holds_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q |-> (lo_q[0] <= out_v_q[0] && out_v_q[0] <= hi_q[0] &&
                  lo_q[1] <= out_v_q[1] && out_v_q[1] <= hi_q[1] &&
                  lo_q[2] <= out_v_q[2] && out_v_q[2] <= hi_q[2]))
    else $error("Bounding box does not contain the vertex it is sent with.");

  a_box_stable_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_vld_q && !m_axis_tready) |=>
      ($stable(lo_q[0]) && $stable(hi_q[0]) && $stable(lo_q[1]) &&
       $stable(hi_q[1]) && $stable(lo_q[2]) && $stable(hi_q[2])))
    else $error("Bounding box changed while the result was stalled.");

endmodule

FILE: hw/rtl/vertex_transform_unit.sv
// Top level of the vertex transform unit: configuration registers, front, queue and back end.
// The unit takes one vertex per clock unless the sink stalls and returns one result per
// vertex, in order: the transformed vertex and the bounding box of all vertices since the
// last restart. Sustained rate is one vertex per cycle while the sink accepts every result.
// An accepted request passes through the front register, the queue and the back pipeline
// stages (multiply, add and round, shift and saturate, box update). The box update is a
// compare and select loop closed on its own register, so consecutive vertices follow each
// other without gaps. The queue of QUEUE_DEPTH entries lets the front keep accepting while
// the back end is held by the sink. Configuration registers are to be written only while
// the unit is empty; the unit does not enforce it, and cfg_ready_o is always high.
module vertex_transform_unit #(
  parameter int unsigned QUEUE_DEPTH = vtu_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // in_x, in_y, in_z
  input  logic [3*vtu_pkg::COORD_W-1:0]     s_axis_tdata,
  // restart
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x, out_y, out_z, box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z
  output logic [9*vtu_pkg::COORD_W-1:0]     m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vtu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vtu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [2:0]     mode_q;
  vtu_pkg::cfg_t  cfg_q;
  logic           cfg_we;

  vtu_pkg::item_t front_item;
  logic           front_valid, front_ready;
  vtu_pkg::item_t queue_item;
  logic           queue_valid, queue_ready;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q             <= vtu_pkg::MODE_RST;
      cfg_q.cos_coef     <= vtu_pkg::COS_RST;
      cfg_q.sin_coef     <= vtu_pkg::SIN_RST;
      cfg_q.scale_factor <= vtu_pkg::SCALE_RST;
      cfg_q.shift_amount <= vtu_pkg::SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        vtu_pkg::REG_MODE:  mode_q             <= cfg_data_i[2:0];
        vtu_pkg::REG_COS:   cfg_q.cos_coef     <= cfg_data_i[15:0];
        vtu_pkg::REG_SIN:   cfg_q.sin_coef     <= cfg_data_i[15:0];
        vtu_pkg::REG_SCALE: cfg_q.scale_factor <= cfg_data_i;
        vtu_pkg::REG_SHIFT: cfg_q.shift_amount <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vtu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .mode_i        (mode_q),
    .item_o        (front_item),
    .valid_o       (front_valid),
    .ready_i       (front_ready)
  );

  vtu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (front_item),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .item_o  (queue_item),
    .valid_o (queue_valid),
    .ready_i (queue_ready)
  );

  vtu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (queue_item),
    .valid_i       (queue_valid),
    .ready_o       (queue_ready),
    .cfg_i         (cfg_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: verif/tb_vertex_transform_unit.sv
// Self-checking testbench for the vertex transform unit: transforms, saturation and box tracking.
`timescale 1ns / 1ps

module tb_vertex_transform_unit;

  localparam int unsigned VERTEX_W     = 3 * vtu_pkg::COORD_W;
  localparam int unsigned RESULT_W     = 9 * vtu_pkg::COORD_W;
  localparam int unsigned ROT_FRAC     = 14;
  localparam int unsigned SCALE_FRAC   = 16;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam logic [vtu_pkg::COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [vtu_pkg::COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [vtu_pkg::COEF_W-1:0]  COEF_MAX  = 16'h7fff;
  localparam logic [vtu_pkg::COEF_W-1:0]  COEF_MIN  = 16'h8000;

  localparam logic [vtu_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = vtu_pkg::REG_SHIFT + 3'd1;
  localparam logic [vtu_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  class transform_box_tracker;
    logic [2:0]          mode;
    longint              cos_q;
    longint              sin_q;
    longint              scale_q;
    longint              shift_q;
    longint              low_corner[3];
    longint              high_corner[3];
    logic [RESULT_W-1:0] expected_vertices[$];
    int unsigned         mismatches;

    function new();
      int i;
      mode    = vtu_pkg::MODE_RST;
      cos_q   = longint'($signed(vtu_pkg::COS_RST));
      sin_q   = longint'($signed(vtu_pkg::SIN_RST));
      scale_q = longint'($signed(vtu_pkg::SCALE_RST));
      shift_q = longint'($signed(vtu_pkg::SHIFT_RST));
      for (i = 0; i < 3; i++) begin
        low_corner[i]  = longint'($signed(COORD_MAX));
        high_corner[i] = longint'($signed(COORD_MIN));
      end
      mismatches = 0;
    endfunction

    function void set_register(logic [vtu_pkg::CFG_IDX_W-1:0] idx,
                               logic [vtu_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        vtu_pkg::REG_MODE:  mode = data[2:0];
        vtu_pkg::REG_COS:   cos_q = longint'($signed(data[vtu_pkg::COEF_W-1:0]));
        vtu_pkg::REG_SIN:   sin_q = longint'($signed(data[vtu_pkg::COEF_W-1:0]));
        vtu_pkg::REG_SCALE: scale_q = longint'($signed(data[vtu_pkg::COORD_W-1:0]));
        vtu_pkg::REG_SHIFT: shift_q = longint'($signed(data[vtu_pkg::COORD_W-1:0]));
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'($signed(COORD_MAX))) return longint'($signed(COORD_MAX));
      if (v < longint'($signed(COORD_MIN))) return longint'($signed(COORD_MIN));
      return v;
    endfunction

    // Divide by 2^frac, rounding half up, then saturate.
    function longint round_down(longint acc, int unsigned frac);
      return clamp32((acc + (64'sd1 <<< (frac - 1))) >>> frac);
    endfunction

    function void rotate_pair(inout longint a, inout longint b);
      longint pa;
      longint pb;
      pa = a;
      pb = b;
      a = round_down(pa * cos_q - pb * sin_q, ROT_FRAC);
      b = round_down(pa * sin_q + pb * cos_q, ROT_FRAC);
    endfunction

    function void note_vertex(logic [VERTEX_W-1:0] data, logic restart);
      longint              v[3];
      logic [RESULT_W-1:0] want;
      int                  i;
      for (i = 0; i < 3; i++) begin
        v[i] = longint'($signed(data[i*vtu_pkg::COORD_W +: vtu_pkg::COORD_W]));
      end
      case (mode)
        vtu_pkg::MODE_ROT_X:   rotate_pair(v[1], v[2]);
        vtu_pkg::MODE_ROT_Y:   rotate_pair(v[0], v[2]);
        vtu_pkg::MODE_ROT_Z:   rotate_pair(v[0], v[1]);
        vtu_pkg::MODE_SCALE:
          for (i = 0; i < 3; i++) v[i] = round_down(v[i] * scale_q, SCALE_FRAC);
        vtu_pkg::MODE_SHIFT_X: v[0] = clamp32(v[0] + shift_q);
        vtu_pkg::MODE_SHIFT_Y: v[1] = clamp32(v[1] + shift_q);
        vtu_pkg::MODE_SHIFT_Z: v[2] = clamp32(v[2] + shift_q);
        default: ;
      endcase
      for (i = 0; i < 3; i++) begin
        if (restart) begin
          low_corner[i]  = v[i];
          high_corner[i] = v[i];
        end else begin
          if (v[i] < low_corner[i]) low_corner[i] = v[i];
          if (v[i] > high_corner[i]) high_corner[i] = v[i];
        end
        want[i*vtu_pkg::COORD_W +: vtu_pkg::COORD_W] = v[i][vtu_pkg::COORD_W-1:0];
        want[(3+2*i)*vtu_pkg::COORD_W +: vtu_pkg::COORD_W] =
          low_corner[i][vtu_pkg::COORD_W-1:0];
        want[(4+2*i)*vtu_pkg::COORD_W +: vtu_pkg::COORD_W] =
          high_corner[i][vtu_pkg::COORD_W-1:0];
      end
      expected_vertices.insert(expected_vertices.size(), want);
    endfunction

    function void check_vertex(logic [RESULT_W-1:0] got);
      logic [RESULT_W-1:0] want;
      string               field_names[9];
      int                  f;
      field_names = '{"out_x", "out_y", "out_z", "box_min_x", "box_max_x",
                      "box_min_y", "box_max_y", "box_min_z", "box_max_z"};
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("Unexpected result %h", got);
        return;
      end
      want = expected_vertices.pop_front();
      for (f = 0; f < 9; f++) begin
        if (got[f*vtu_pkg::COORD_W +: vtu_pkg::COORD_W] !==
            want[f*vtu_pkg::COORD_W +: vtu_pkg::COORD_W]) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Mismatch on %s: expected %0d, got %0d", field_names[f],
                     $signed(want[f*vtu_pkg::COORD_W +: vtu_pkg::COORD_W]),
                     $signed(got[f*vtu_pkg::COORD_W +: vtu_pkg::COORD_W]));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_vertices.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [VERTEX_W-1:0]            s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [RESULT_W-1:0]            m_axis_tdata;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [vtu_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [vtu_pkg::CFG_DATA_W-1:0] cfg_data_i;

  transform_box_tracker tracker;
  int unsigned          src_gap_pct;
  int unsigned          sink_stall_pct;
  int unsigned          cycle_count;

  vertex_transform_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) tracker.check_vertex(m_axis_tdata);
  end

  // The sink stalls in random bursts while sink_stall_pct is nonzero.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_vertex(logic [vtu_pkg::COORD_W-1:0] x, logic [vtu_pkg::COORD_W-1:0] y,
                             logic [vtu_pkg::COORD_W-1:0] z, logic restart);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tuser  <= restart;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_vertex({z, y, x}, restart);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_reg(logic [vtu_pkg::CFG_IDX_W-1:0] idx,
                           logic [vtu_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    tracker.set_register(idx, data);
  endtask

  // Writes every register, with random filler above the used bits, plus one unused index.
  task automatic apply_config(logic [2:0] mode, logic [vtu_pkg::COEF_W-1:0] cos_v,
                              logic [vtu_pkg::COEF_W-1:0] sin_v,
                              logic [vtu_pkg::COORD_W-1:0] scale_v,
                              logic [vtu_pkg::COORD_W-1:0] shift_v);
    logic [vtu_pkg::CFG_DATA_W-1:0] data;
    wait_idle();
    data = $urandom;
    data[2:0] = mode;
    write_reg(vtu_pkg::REG_MODE, data);
    data = $urandom;
    data[vtu_pkg::COEF_W-1:0] = cos_v;
    write_reg(vtu_pkg::REG_COS, data);
    data = $urandom;
    data[vtu_pkg::COEF_W-1:0] = sin_v;
    write_reg(vtu_pkg::REG_SIN, data);
    write_reg(vtu_pkg::REG_SCALE, scale_v);
    write_reg(vtu_pkg::REG_SHIFT, shift_v);
    write_reg(vtu_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [vtu_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2, 3: return vtu_pkg::COEF_W'(int'($urandom_range(0, 32768)) - 16384);
      default: return vtu_pkg::COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [vtu_pkg::COORD_W-1:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4: return vtu_pkg::COORD_W'(int'($urandom_range(0, 2**19)) - 2**18);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [vtu_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      2: return vtu_pkg::COORD_W'(int'($urandom_range(0, 4000)) - 2000);
      default: return vtu_pkg::COORD_W'(int'($urandom_range(0, 2**26)) - 2**25);
    endcase
  endfunction

  task automatic run_phase(int unsigned n_items, bit quiet);
    int unsigned k;
    logic        restart;
    apply_config(3'($urandom_range(vtu_pkg::MODE_IDENTITY, vtu_pkg::MODE_SHIFT_Z)),
                 rand_coef(), rand_coef(), rand_q16(), rand_q16());
    if (quiet) begin
      src_gap_pct    = 0;
      sink_stall_pct = 0;
    end else begin
      src_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
    end
    for (k = 0; k < n_items; k++) begin
      restart = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
      send_vertex(rand_coord(), rand_coord(), rand_coord(), restart);
    end
  endtask

  initial begin
    int unsigned p;
    tracker        = new();
    src_gap_pct    = 10;
    sink_stall_pct = 10;
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, first vertex without a restart, then a restart.
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, '1, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 32'd1, 1'b0);
    send_vertex(32'd5, -32'sd5, 32'd7, 1'b1);

    // Rotation by half a unit exposes the round-half-up rule.
    apply_config(vtu_pkg::MODE_ROT_X, 16'sd8192, 16'sd0, vtu_pkg::SCALE_RST,
                 vtu_pkg::SHIFT_RST);
    send_vertex(32'd0, 32'd1, '1, 1'b0);
    send_vertex(32'd3, COORD_MAX, COORD_MIN, 1'b0);
    apply_config(vtu_pkg::MODE_ROT_X, COEF_MIN, COEF_MAX, vtu_pkg::SCALE_RST,
                 vtu_pkg::SHIFT_RST);
    send_vertex('0, COORD_MAX, COORD_MIN, 1'b1);
    send_vertex('0, COORD_MIN, COORD_MIN, 1'b0);
    apply_config(vtu_pkg::MODE_ROT_Y, 16'sd11585, 16'sd11585, vtu_pkg::SCALE_RST,
                 vtu_pkg::SHIFT_RST);
    send_vertex(32'h0001_0000, '0, 32'h0001_0000, 1'b0);
    send_vertex(COORD_MIN, 32'd1, COORD_MAX, 1'b0);
    apply_config(vtu_pkg::MODE_ROT_Z, COEF_MAX, COEF_MIN, vtu_pkg::SCALE_RST,
                 vtu_pkg::SHIFT_RST);
    send_vertex(COORD_MAX, COORD_MAX, '0, 1'b0);
    send_vertex(COORD_MIN, '1, '0, 1'b1);

    apply_config(vtu_pkg::MODE_SCALE, vtu_pkg::COS_RST, vtu_pkg::SIN_RST, COORD_MIN,
                 vtu_pkg::SHIFT_RST);
    send_vertex(COORD_MIN, COORD_MAX, '0, 1'b0);
    apply_config(vtu_pkg::MODE_SCALE, vtu_pkg::COS_RST, vtu_pkg::SIN_RST, 32'h0000_8000,
                 vtu_pkg::SHIFT_RST);
    send_vertex(32'd1, '1, 32'd3, 1'b0);
    apply_config(vtu_pkg::MODE_SCALE, vtu_pkg::COS_RST, vtu_pkg::SIN_RST, COORD_MAX,
                 vtu_pkg::SHIFT_RST);
    send_vertex(COORD_MAX, COORD_MIN, 32'hffff_0000, 1'b0);

    apply_config(vtu_pkg::MODE_SHIFT_X, vtu_pkg::COS_RST, vtu_pkg::SIN_RST,
                 vtu_pkg::SCALE_RST, COORD_MAX);
    send_vertex(COORD_MAX, '0, '0, 1'b0);
    send_vertex(COORD_MIN, '0, '0, 1'b0);
    apply_config(vtu_pkg::MODE_SHIFT_Y, vtu_pkg::COS_RST, vtu_pkg::SIN_RST,
                 vtu_pkg::SCALE_RST, COORD_MIN);
    send_vertex('0, COORD_MIN, '0, 1'b0);
    apply_config(vtu_pkg::MODE_SHIFT_Z, vtu_pkg::COS_RST, vtu_pkg::SIN_RST,
                 vtu_pkg::SCALE_RST, 32'hffff_0000);
    send_vertex('0, '0, COORD_MIN, 1'b0);
    send_vertex('0, '0, COORD_MAX, 1'b1);

    for (p = 0; p < 12; p++) run_phase(145, 1'b0);
    run_phase(190, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/vtu_pkg.sv
hw/rtl/vtu_front.sv
hw/rtl/vtu_queue.sv
hw/rtl/vtu_back.sv
hw/rtl/vertex_transform_unit.sv
verif/tb_vertex_transform_unit.sv
